// ===== hw/rtl/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

	// result kinds
	localparam logic [1:0] K_BYTE = 2'd0;
	localparam logic [1:0] K_TEND = 2'd1;
	localparam logic [1:0] K_LEND = 2'd2;

	// line-end status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SQ_OPEN  = 2'd1;
	localparam logic [1:0] ST_DQ_OPEN  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// special bytes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [7:0] MAX_TOKENS_RESET = 8'd64;
	localparam logic [7:0] COUNT_MAX        = 8'd255;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] token_byte;
		logic [7:0] token_count;
		logic [1:0] status;
		logic       last;
	} res_t;

	function automatic res_t make_res(input logic [1:0] k, input logic [7:0] b,
			input logic [7:0] cnt, input logic [1:0] st);
		res_t r;
		r.kind        = k;
		r.token_byte  = b;
		r.token_count = cnt;
		r.status      = st;
		r.last        = 1'b0;
		return r;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ===== hw/rtl/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a NUL-terminated command line into tokens with shell-style quoting.
// ----------------------------------------------------------------------------
// One byte of the line enters per transaction on the input channel and is
// held in an input register; a single pass of decode logic then turns it into
// zero, one or two results (token byte, end of token, end of line) that are
// written into a two-entry output buffer. A new byte is taken in every cycle
// while each byte produces at most one result and the output is not stalled.
// A byte that produces two results (NUL closing a word, or the byte after a
// backslash inside double quotes when it is NUL or not one of backslash,
// double quote or dollar) keeps the input stalled while the output buffer
// drains. Each byte passes through the input register and then the output
// buffer before its first result appears. max_tokens is written through
// the APB port at address 0 and is read back there.
module command_line_tokenizer
	import clt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  token_byte,
	output logic [7:0]  token_count,
	output logic [1:0]  status,
	output logic        last
);

	localparam logic [2:0] M_BETWEEN = 3'd0;
	localparam logic [2:0] M_WORD    = 3'd1;
	localparam logic [2:0] M_SQ      = 3'd2;
	localparam logic [2:0] M_DQ      = 3'd3;
	localparam logic [2:0] M_DQ_ESC  = 3'd4;

	logic [7:0] max_tokens_q;
	logic [2:0] mode_q;
	logic [7:0] done_q;
	logic       ovf_q;

	logic       valid_s1;
	logic [7:0] char_s1;

	res_t       slot0_q, slot1_q;
	logic [1:0] cnt_q;

	logic       take, buf_free, advance, in_acc;
	res_t       r0, r1;
	logic [1:0] n;
	logic [2:0] nmode;
	logic [7:0] ndone, inc;
	logic       novf;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, max_tokens_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q <= MAX_TOKENS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			max_tokens_q <= pwdata[7:0];
		end
	end

	// handshakes
	assign take     = out_valid && !out_stall;
	assign buf_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);
	assign advance  = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= char_in;
		end
	end

	// decode of one byte against the scanner state
	always_comb begin
		r0    = make_res(K_BYTE, 8'd0, 8'd0, ST_OK);
		r1    = make_res(K_BYTE, 8'd0, 8'd0, ST_OK);
		n     = 2'd0;
		nmode = mode_q;
		ndone = done_q;
		novf  = ovf_q;
		inc   = (done_q < COUNT_MAX) ? done_q + 8'd1 : done_q;
		case (mode_q)
			M_WORD: begin
				if (char_s1 == CH_NUL) begin
					if (!ovf_q) begin
						r0 = make_res(K_TEND, 8'd0, inc, ST_OK);
						r1 = make_res(K_LEND, 8'd0, inc, ST_OK);
						n  = 2'd2;
					end else begin
						r0 = make_res(K_LEND, 8'd0, done_q, ST_OVERFLOW);
						n  = 2'd1;
					end
					nmode = M_BETWEEN;
					ndone = 8'd0;
					novf  = 1'b0;
				end else if (is_ws(char_s1)) begin
					if (!ovf_q) begin
						r0    = make_res(K_TEND, 8'd0, inc, ST_OK);
						n     = 2'd1;
						ndone = inc;
					end
					nmode = M_BETWEEN;
				end else if (!ovf_q) begin
					r0 = make_res(K_BYTE, char_s1, done_q, ST_OK);
					n  = 2'd1;
				end
			end
			M_SQ, M_DQ: begin
				if (char_s1 == CH_NUL) begin
					r0 = make_res(K_LEND, 8'd0, done_q,
						(mode_q == M_SQ) ? ST_SQ_OPEN : ST_DQ_OPEN);
					n     = 2'd1;
					nmode = M_BETWEEN;
					ndone = 8'd0;
					novf  = 1'b0;
				end else if ((mode_q == M_SQ && char_s1 == CH_SQUOTE) ||
						(mode_q == M_DQ && char_s1 == CH_DQUOTE)) begin
					if (!ovf_q) begin
						r0    = make_res(K_TEND, 8'd0, inc, ST_OK);
						n     = 2'd1;
						ndone = inc;
					end
					nmode = M_BETWEEN;
				end else if (mode_q == M_DQ && char_s1 == CH_BSLASH) begin
					nmode = M_DQ_ESC;
				end else if (!ovf_q) begin
					r0 = make_res(K_BYTE, char_s1, done_q, ST_OK);
					n  = 2'd1;
				end
			end
			M_DQ_ESC: begin
				if (char_s1 == CH_BSLASH || char_s1 == CH_DQUOTE ||
						char_s1 == CH_DOLLAR) begin
					if (!ovf_q) begin
						r0 = make_res(K_BYTE, char_s1, done_q, ST_OK);
						n  = 2'd1;
					end
					nmode = M_DQ;
				end else if (char_s1 == CH_NUL) begin
					// the held backslash still goes out before the line ends, unless dropped
					if (!ovf_q) begin
						r0 = make_res(K_BYTE, CH_BSLASH, done_q, ST_OK);
						r1 = make_res(K_LEND, 8'd0, done_q, ST_DQ_OPEN);
						n  = 2'd2;
					end else begin
						r0 = make_res(K_LEND, 8'd0, done_q, ST_DQ_OPEN);
						n  = 2'd1;
					end
					nmode = M_BETWEEN;
					ndone = 8'd0;
					novf  = 1'b0;
				end else begin
					if (!ovf_q) begin
						r0 = make_res(K_BYTE, CH_BSLASH, done_q, ST_OK);
						r1 = make_res(K_BYTE, char_s1, done_q, ST_OK);
						n  = 2'd2;
					end
					nmode = M_DQ;
				end
			end
			default: begin
				if (char_s1 == CH_NUL) begin
					r0 = make_res(K_LEND, 8'd0, done_q, ovf_q ? ST_OVERFLOW : ST_OK);
					n     = 2'd1;
					nmode = M_BETWEEN;
					ndone = 8'd0;
					novf  = 1'b0;
				end else if (is_ws(char_s1)) begin
					nmode = M_BETWEEN;
				end else begin
					// a token starting past the limit is dropped whole
					novf = ovf_q || (done_q >= max_tokens_q);
					if (char_s1 == CH_SQUOTE) begin
						nmode = M_SQ;
					end else if (char_s1 == CH_DQUOTE) begin
						nmode = M_DQ;
					end else begin
						nmode = M_WORD;
						if (!novf) begin
							r0 = make_res(K_BYTE, char_s1, done_q, ST_OK);
							n  = 2'd1;
						end
					end
				end
			end
		endcase
		if (n == 2'd1) begin
			r0.last = 1'b1;
		end else if (n == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_BETWEEN;
			done_q <= 8'd0;
			ovf_q  <= 1'b0;
		end else if (advance) begin
			mode_q <= nmode;
			done_q <= ndone;
			ovf_q  <= novf;
		end
	end

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (advance) begin
			cnt_q <= n;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (take) begin
			slot0_q <= slot1_q;
		end
	end

	assign out_valid   = (cnt_q != 2'd0);
	assign kind        = slot0_q.kind;
	assign token_byte  = slot0_q.token_byte;
	assign token_count = slot0_q.token_count;
	assign status      = slot0_q.status;
	assign last        = slot0_q.last;

endmodule

// ===== hw/rtl/clt_checker.sv =====
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks on the result stream of the command line tokenizer.
// ----------------------------------------------------------------------------
module clt_checker
	import clt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic [7:0] token_byte,
	input logic [7:0] token_count,
	input logic [1:0] status,
	input logic       last
);

	// status only means something on end of line
	a_status_lend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != K_LEND) |-> status == ST_OK)
		else $error("status set on a result that is not end of line");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != K_BYTE) |-> token_byte == 8'd0)
		else $error("token byte set on a non-byte result");

	// end of line is always the final result of its byte
	a_lend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_LEND) |-> last)
		else $error("end of line without last");

	a_tend_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_TEND) |-> token_count != 8'd0)
		else $error("end of token reports zero tokens");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) &&
			$stable(token_byte) && $stable(token_count) &&
			$stable(status) && $stable(last))
		else $error("stalled result changed");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (.*);

// ===== verif/command_line_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer_tb
// Self-checking bench for the command line tokenizer. Lines are fed one byte
// per transaction, and a behavioural predictor tracks quoting, escapes and the
// token limit to build the expected result stream. Every output transaction is
// compared field by field against that stream, under several max_tokens
// settings and with mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb
	import clt_pkg::*;
();

	localparam logic [2:0] ADDR_MAX_TOKENS = 3'd0;
	localparam int WD_LIMIT    = 3000;
	localparam int SETTLE_CYC  = 8;
	localparam int HOLD_CYC    = 300;

	typedef enum logic [2:0] {
		SCAN_BETWEEN,
		SCAN_WORD,
		SCAN_SQ,
		SCAN_DQ,
		SCAN_DQ_ESC
	} scan_e;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_in;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  token_byte;
	logic [7:0]  token_count;
	logic [1:0]  status;
	logic        last;

	command_line_tokenizer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_in     (char_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.token_byte  (token_byte),
		.token_count (token_count),
		.status      (status),
		.last        (last)
	);

	// predictor state
	scan_e      lex_mode;
	logic [7:0] done_cnt;
	bit         dropping;
	logic [7:0] token_limit;

	res_t pending_results[$];
	res_t step_results[$];
	res_t want_r;

	int n_err;
	int n_sent;
	int n_lines;
	int n_checked;
	int send_idle_pct;
	int stall_pct;
	int hold_req;
	int quiet_cyc;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit blank_char(logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic void push_res(logic [1:0] k, logic [7:0] b, logic [1:0] st);
		res_t r;
		r.kind        = k;
		r.token_byte  = b;
		r.token_count = done_cnt;
		r.status      = st;
		r.last        = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void emit_byte(logic [7:0] c);
		if (!dropping)
			push_res(K_BYTE, c, ST_OK);
	endfunction

	function automatic void close_token();
		if (!dropping) begin
			if (done_cnt < COUNT_MAX)
				done_cnt++;
			push_res(K_TEND, 8'h00, ST_OK);
		end
		lex_mode = SCAN_BETWEEN;
	endfunction

	function automatic void close_line(logic [1:0] quote_st);
		logic [1:0] st;
		st = (quote_st != ST_OK) ? quote_st : (dropping ? ST_OVERFLOW : ST_OK);
		push_res(K_LEND, 8'h00, st);
		lex_mode = SCAN_BETWEEN;
		done_cnt = 8'd0;
		dropping = 1'b0;
	endfunction

	function automatic void open_token(scan_e mode);
		if (done_cnt >= token_limit)
			dropping = 1'b1;
		lex_mode = mode;
	endfunction

	function automatic void predict_char(logic [7:0] c);
		step_results.delete();
		case (lex_mode)
			SCAN_WORD: begin
				if (c == CH_NUL) begin
					close_token();
					close_line(ST_OK);
				end else if (blank_char(c))
					close_token();
				else
					emit_byte(c);
			end
			SCAN_SQ: begin
				if (c == CH_NUL)
					close_line(ST_SQ_OPEN);
				else if (c == CH_SQUOTE)
					close_token();
				else
					emit_byte(c);
			end
			SCAN_DQ: begin
				if (c == CH_NUL)
					close_line(ST_DQ_OPEN);
				else if (c == CH_DQUOTE)
					close_token();
				else if (c == CH_BSLASH)
					lex_mode = SCAN_DQ_ESC;
				else
					emit_byte(c);
			end
			SCAN_DQ_ESC: begin
				if (c == CH_BSLASH || c == CH_DQUOTE || c == CH_DOLLAR) begin
					emit_byte(c);
					lex_mode = SCAN_DQ;
				end else if (c == CH_NUL) begin
					// a lone backslash survives before the line ends, unless dropped
					emit_byte(CH_BSLASH);
					close_line(ST_DQ_OPEN);
				end else begin
					emit_byte(CH_BSLASH);
					emit_byte(c);
					lex_mode = SCAN_DQ;
				end
			end
			default: begin
				if (c == CH_NUL)
					close_line(ST_OK);
				else if (blank_char(c))
					lex_mode = SCAN_BETWEEN;
				else if (c == CH_SQUOTE)
					open_token(SCAN_SQ);
				else if (c == CH_DQUOTE)
					open_token(SCAN_DQ);
				else begin
					open_token(SCAN_WORD);
					emit_byte(c);
				end
			end
		endcase
		if (step_results.size() > 0)
			step_results[$].last = 1'b1;
		foreach (step_results[i])
			pending_results.push_back(step_results[i]);
	endfunction

	function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			n_err++;
		end
	endfunction

	// output checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d byte %0d", kind, token_byte);
				n_err++;
			end else begin
				want_r = pending_results.pop_front();
				cmp_field("kind", 8'(want_r.kind), 8'(kind));
				cmp_field("token_byte", want_r.token_byte, token_byte);
				cmp_field("token_count", want_r.token_count, token_count);
				cmp_field("status", 8'(want_r.status), 8'(status));
				cmp_field("last", 8'(want_r.last), 8'(last));
				n_checked++;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				n = hold_req;
				hold_req = 0;
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		quiet_cyc = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(psel && penable && pready))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= WD_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_char(logic [7:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_char(c);
		n_sent++;
		if (c == CH_NUL)
			n_lines++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// bytes that give no result may still be in flight
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic apb_access(bit wr, logic [7:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_MAX_TOKENS;
		pwdata  <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (!wr && prdata !== 32'(v)) begin
			$error("prdata mismatch: expected %0d, got %0d", v, prdata);
			n_err++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_max_tokens(logic [7:0] v);
		wait_idle();
		apb_access(1'b1, v);
		token_limit = v;
		@(negedge clk);
		apb_access(1'b0, v);
	endtask

	function automatic logic [7:0] rand_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : 8'(9 + r);
	endfunction

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (blank_char(c));
		return c;
	endfunction

	function automatic logic [7:0] word_start();
		logic [7:0] c;
		do
			c = word_char();
		while (c == CH_SQUOTE || c == CH_DQUOTE);
		return c;
	endfunction

	function automatic logic [7:0] sq_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_SQUOTE);
		return c;
	endfunction

	task automatic send_dq_piece();
		logic [7:0] c;
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) begin
			send_char(CH_BSLASH);
			case ($urandom_range(0, 3))
				0: send_char(CH_BSLASH);
				1: send_char(CH_DQUOTE);
				2: send_char(CH_DOLLAR);
				default: send_char(8'($urandom_range(1, 255)));
			endcase
		end else begin
			do
				c = 8'($urandom_range(1, 255));
			while (c == CH_DQUOTE || c == CH_BSLASH);
			send_char(c);
		end
	endtask

	// one line of tokens; a broken line ends inside an open quote
	task automatic send_line(int ntok, bit broken);
		int sel;
		int len;
		bit after_quote;
		logic [7:0] q;
		after_quote = 1'b0;
		repeat ($urandom_range(0, 2)) send_char(rand_blank());
		for (int t = 0; t < ntok; t++) begin
			// a closed quote may be followed straight by the next token
			if (t > 0 && !(after_quote && $urandom_range(0, 3) == 0))
				repeat ($urandom_range(1, 3)) send_char(rand_blank());
			sel = $urandom_range(0, 9);
			after_quote = (sel >= 5);
			len = $urandom_range(1, 6);
			if (sel < 5) begin
				send_char(word_start());
				repeat (len - 1) send_char(word_char());
			end else if (sel < 7) begin
				send_char(CH_SQUOTE);
				repeat (len) send_char(sq_char());
				send_char(CH_SQUOTE);
			end else if (sel < 9) begin
				send_char(CH_DQUOTE);
				repeat (len) send_dq_piece();
				send_char(CH_DQUOTE);
			end else begin
				q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
				send_char(q);
				send_char(q);
			end
		end
		repeat ($urandom_range(0, 2)) send_char(rand_blank());
		if (broken) begin
			send_char(CH_SPACE);
			if ($urandom_range(0, 1)) begin
				send_char(CH_SQUOTE);
				repeat ($urandom_range(0, 4)) send_char(sq_char());
			end else begin
				send_char(CH_DQUOTE);
				repeat ($urandom_range(0, 4)) send_dq_piece();
				if ($urandom_range(0, 1))
					send_char(CH_BSLASH);
			end
		end
		send_char(CH_NUL);
	endtask

	function automatic int rand_ntok();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
	endfunction

	task automatic test_register_reset();
		apb_access(1'b0, MAX_TOKENS_RESET);
	endtask

	task automatic test_directed();
		logic [7:0] dir_bytes[] = '{
			8'h61, 8'hFF, CH_SPACE,
			CH_SQUOTE, 8'h78, CH_SQUOTE, CH_SPACE,
			CH_DQUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_DQUOTE,
			CH_BSLASH, CH_DOLLAR, CH_BSLASH, 8'h71, CH_DQUOTE,
			CH_DQUOTE, CH_DQUOTE, CH_TAB, CH_NUL,
			CH_SQUOTE, 8'h7A, CH_NUL,
			CH_DQUOTE, CH_BSLASH, CH_NUL
		};
		foreach (dir_bytes[i])
			send_char(dir_bytes[i]);
		wait_idle();
	endtask

	task automatic test_too_many_tokens();
		logic [7:0] limits[3] = '{8'd1, 8'd0, 8'd2};
		foreach (limits[i]) begin
			set_max_tokens(limits[i]);
			repeat (3) send_line($urandom_range(2, 5), 1'b0);
			send_line(3, 1'b1);
		end
		wait_idle();
	endtask

	task automatic test_random_lines();
		int idle_tab[4]  = '{0, 61, 0, 14};
		int stall_tab[4] = '{0, 0, 61, 14};
		logic [7:0] limits[8];
		int target;
		int r;
		limits = '{8'd255, 8'd1, 8'd2, 8'd0, 8'd3, MAX_TOKENS_RESET,
			8'($urandom_range(1, 255)), 8'($urandom_range(4, 12))};
		for (int p = 0; p < 4; p++) begin
			for (int s = 0; s < 2; s++) begin
				set_max_tokens(limits[2 * p + s]);
				send_idle_pct = idle_tab[p];
				stall_pct     = stall_tab[p];
				target = n_sent + 170;
				while (n_sent < target) begin
					r = $urandom_range(0, 19);
					if (r < 17)
						send_line(rand_ntok(), 1'b0);
					else if (r < 19)
						send_line(rand_ntok(), 1'b1);
					else
						repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
				end
			end
		end
		wait_idle();
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	task automatic test_output_hold_off();
		set_max_tokens(MAX_TOKENS_RESET);
		hold_req = HOLD_CYC;
		repeat (4) send_line(6, 1'b0);
		wait_idle();
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		char_in       = '0;
		n_err         = 0;
		n_sent        = 0;
		n_lines       = 0;
		n_checked     = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 0;
		lex_mode      = SCAN_BETWEEN;
		done_cnt      = 8'd0;
		dropping      = 1'b0;
		token_limit   = MAX_TOKENS_RESET;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_reset();
		test_directed();
		test_too_many_tokens();
		test_random_lines();
		test_output_hold_off();

		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			n_err++;
		end
		$display("run covered %0d bytes over %0d lines, %0d results compared",
			n_sent, n_lines, n_checked);
		$display("quotes, escapes, token limits 0 to 255, idle mixes and a long output hold");
		if (n_err == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
